// File: design/atij_pkg.sv
// shared constants and helpers for the accelerometer tilt innovation block
package atij_pkg;

  localparam int TableLen = 24;
  localparam int DefCordicIterations = 16;
  localparam int DefAngleWidth = 16;
  localparam int GainQ15 = 19899;
  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam logic [14:0] GravityReset = 15'd16384;

  // arctangent of 2^-i with 30 fraction bits
  function automatic longint atan_q30(input int i);
    case (i)
      0: atan_q30 = 843314857;
      1: atan_q30 = 497837829;
      2: atan_q30 = 263043837;
      3: atan_q30 = 133525159;
      4: atan_q30 = 67021687;
      5: atan_q30 = 33543516;
      6: atan_q30 = 16775851;
      7: atan_q30 = 8388437;
      8: atan_q30 = 4194283;
      9: atan_q30 = 2097149;
      default: atan_q30 = longint'(64'sd1) <<< (30 - i);
    endcase
  endfunction

  // round a 30-fraction-bit constant to the working angle precision
  function automatic longint to_angle(input longint q30, input int aw);
    int sh;
    sh = 33 - aw;
    to_angle = (q30 + (longint'(64'sd1) <<< (sh - 1))) >>> sh;
  endfunction

endpackage

// File: design/atij_cordic.sv
// pipelined rotation-mode cordic giving saturated q1.15 sine and cosine
module atij_cordic #(
  parameter int CORDIC_ITERATIONS = atij_pkg::DefCordicIterations,
  parameter int ANGLE_WIDTH = atij_pkg::DefAngleWidth
) (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [15:0]  angle,
  output logic signed [15:0]  sin_q,
  output logic signed [15:0]  cos_q
);

  localparam int N = (CORDIC_ITERATIONS < atij_pkg::TableLen) ? CORDIC_ITERATIONS
                                                                : atij_pkg::TableLen;
  localparam int ZW = ANGLE_WIDTH + 2;
  localparam int XW = 19;
  localparam longint HalfPi = atij_pkg::to_angle(atij_pkg::HalfPiQ30, ANGLE_WIDTH);
  localparam longint PiA = atij_pkg::to_angle(atij_pkg::PiQ30, ANGLE_WIDTH);

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] zs [N+1];
  logic signed [XW-1:0] xs [N+1];
  logic signed [XW-1:0] ys [N+1];
  logic                 fl [N+1];

  // rescale to ANGLE_WIDTH-3 fraction bits
  always_comb begin
    if (ANGLE_WIDTH >= 16) begin
      z_in = ZW'(angle) <<< (ANGLE_WIDTH - 16);
    end else begin
      z_in = ZW'(angle >>> (16 - ANGLE_WIDTH));
    end
  end

  // quadrant fold into the first register stage
  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= XW'(atij_pkg::GainQ15);
      ys[0] <= '0;
      if (z_in > ZW'(HalfPi)) begin
        zs[0] <= z_in - ZW'(PiA);
        fl[0] <= 1'b1;
      end else if (z_in < -ZW'(HalfPi)) begin
        zs[0] <= z_in + ZW'(PiA);
        fl[0] <= 1'b1;
      end else begin
        zs[0] <= z_in;
        fl[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam longint A = atij_pkg::to_angle(atij_pkg::atan_q30(i), ANGLE_WIDTH);
    always_ff @(posedge clk) begin
      if (adv) begin
        fl[i+1] <= fl[i];
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ZW'(A);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ZW'(A);
        end
      end
    end
  end

  logic signed [XW-1:0] xf, yf;
  always_comb begin
    xf = fl[N] ? -xs[N] : xs[N];
    yf = fl[N] ? -ys[N] : ys[N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q <= (xf > 19'sd32767) ? 16'sd32767 : (xf < -19'sd32767) ? -16'sd32767 : xf[15:0];
      sin_q <= (yf > 19'sd32767) ? 16'sd32767 : (yf < -19'sd32767) ? -16'sd32767 : yf[15:0];
    end
  end

endmodule

// File: design/accel_tilt_innovation_jacobian.sv
// Predicts the gravity vector from roll and pitch, gives the accelerometer
// innovation and the five nonzero measurement Jacobian terms. Fully
// pipelined: one word enters per cycle unless the output stalls. Stages
// are the fold and saturation registers around CORDIC_ITERATIONS (at most
// 24) unrolled cordic stages, two multiply stages, a rounding stage and the
// output register. A stall on the output holds the whole pipeline, so
// in_stall is high exactly while a finished word waits at the output.
module accel_tilt_innovation_jacobian #(
  parameter int CORDIC_ITERATIONS = atij_pkg::DefCordicIterations,
  parameter int ANGLE_WIDTH = atij_pkg::DefAngleWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        gravity_counts,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] innov_x,
  output logic signed [16:0] innov_y,
  output logic signed [16:0] innov_z,
  output logic signed [15:0] dhx_dpitch,
  output logic signed [15:0] dhy_droll,
  output logic signed [15:0] dhy_dpitch,
  output logic signed [15:0] dhz_droll,
  output logic signed [15:0] dhz_dpitch
);

  localparam int N = (CORDIC_ITERATIONS < atij_pkg::TableLen) ? CORDIC_ITERATIONS
                                                                : atij_pkg::TableLen;
  localparam int CL = N + 2;   // cordic latency
  localparam int L = CL + 4;   // total latency to last pipe stage

  logic [14:0] grav;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= atij_pkg::GravityReset;
    end else if (cfg_valid) begin
      grav <= gravity_counts;
    end
  end

  // pipeline advances unless the last stage holds a word that cannot leave
  logic adv;
  logic [L-1:0] vld;
  assign adv = !(vld[L-1] && out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  logic signed [15:0] s0, c0, s1, c1;
  atij_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk(clk), .adv(adv), .angle(roll_angle), .sin_q(s0), .cos_q(c0));
  atij_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk(clk), .adv(adv), .angle(pitch_angle), .sin_q(s1), .cos_q(c1));

  // accel delay line aligned to cordic output
  logic signed [15:0] ax_d [CL], ay_d [CL], az_d [CL];
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_d[0] <= accel_x;
      ay_d[0] <= accel_y;
      az_d[0] <= accel_z;
      for (int k = 1; k < CL; k++) begin
        ax_d[k] <= ax_d[k-1];
        ay_d[k] <= ay_d[k-1];
        az_d[k] <= az_d[k-1];
      end
    end
  end

  // stage a: trig products and single-factor gravity products
  logic signed [31:0] p_s0c1, p_c0c1, p_s0s1, p_c0s1;
  logic signed [31:0] p_s1g, p_c1g;
  logic signed [15:0] axa, aya, aza;
  logic signed [15:0] ga;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_s0c1 <= s0 * c1;
      p_c0c1 <= c0 * c1;
      p_s0s1 <= s0 * s1;
      p_c0s1 <= c0 * s1;
      p_s1g <= s1 * $signed({1'b0, grav});
      p_c1g <= c1 * $signed({1'b0, grav});
      ga <= $signed({1'b0, grav});
      axa <= ax_d[CL-1];
      aya <= ay_d[CL-1];
      aza <= az_d[CL-1];
    end
  end

  // stage b: times gravity (30-bit products fit 32x16)
  logic signed [47:0] q_s0c1, q_c0c1, q_s0s1, q_c0s1;
  logic signed [31:0] q_s1g, q_c1g;
  logic signed [15:0] axb, ayb, azb;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_s0c1 <= p_s0c1 * ga;
      q_c0c1 <= p_c0c1 * ga;
      q_s0s1 <= p_s0s1 * ga;
      q_c0s1 <= p_c0s1 * ga;
      q_s1g <= p_s1g;
      q_c1g <= p_c1g;
      axb <= axa;
      ayb <= aya;
      azb <= aza;
    end
  end

  // rounding half up
  function automatic logic signed [18:0] rnd2(input logic signed [47:0] p);
    logic signed [47:0] t;
    t = (p + 48'sd536870912) >>> 30;
    rnd2 = t[18:0];
  endfunction
  function automatic logic signed [18:0] rnd1(input logic signed [32:0] p);
    logic signed [32:0] t;
    t = (p + 33'sd16384) >>> 15;
    rnd1 = t[18:0];
  endfunction
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    sat16 = (v > 19'sd32767) ? 16'sd32767 : (v < -19'sd32768) ? -16'sd32768 : v[15:0];
  endfunction
  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    sat17 = (v > 19'sd65535) ? 17'sd65535 : (v < -19'sd65536) ? -17'sd65536 : v[16:0];
  endfunction

  // stage c: rounding
  logic signed [18:0] hx, hy, hz, jx, jyp, jzr, jzp;
  logic signed [15:0] axc, ayc, azc;
  always_ff @(posedge clk) begin
    if (adv) begin
      hx <= rnd1(-(33'(q_s1g)));
      hy <= rnd2(q_s0c1);
      hz <= rnd2(q_c0c1);
      jx <= rnd1(-(33'(q_c1g)));
      jyp <= rnd2(-q_s0s1);
      jzr <= rnd2(-q_s0c1);
      jzp <= rnd2(-q_c0s1);
      axc <= axb;
      ayc <= ayb;
      azc <= azb;
    end
  end

  // stage d: innovation and saturation into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      innov_x <= sat17(19'(axc) - hx);
      innov_y <= sat17(19'(ayc) - hy);
      innov_z <= sat17(19'(azc) - hz);
      dhx_dpitch <= sat16(jx);
      dhy_droll <= sat16(hz);
      dhy_dpitch <= sat16(jyp);
      dhz_droll <= sat16(jzr);
      dhz_dpitch <= sat16(jzp);
    end
  end

  assign out_valid = vld[L-1];

endmodule
